// ===== src/brmc_pkg.sv =====
// brmc_pkg: shared types, constants and sequencer step codes for the
// balance robot motor controller. No dependencies.
`default_nettype none

package brmc_pkg;

  // dividers by a constant run as a multiply by a rounded-up reciprocal
  localparam int DRIVE_DIVISOR = 15;
  localparam int FILT_DIVISOR  = 5;
  localparam int QUOT_NUM_W    = 27;
  localparam int FILT_SHIFT    = QUOT_NUM_W + $clog2(FILT_DIVISOR);
  localparam int DRIVE_SHIFT   = QUOT_NUM_W + $clog2(DRIVE_DIVISOR);
  localparam int RECIP_W       = 29;
  localparam logic [RECIP_W-1:0] FILT_RECIP =
    RECIP_W'(((64'd1 << FILT_SHIFT) + FILT_DIVISOR - 1) / FILT_DIVISOR);
  localparam logic [RECIP_W-1:0] DRIVE_RECIP =
    RECIP_W'(((64'd1 << DRIVE_SHIFT) + DRIVE_DIVISOR - 1) / DRIVE_DIVISOR);

  localparam logic signed [26:0] INTEG_LIMIT = 27'sd2560000;
  localparam logic signed [15:0] TILT_LIMIT  = 16'sd2560;
  localparam logic [12:0]        COMMAND_MAX = 13'd7200;

  // register indexes
  localparam logic [2:0] REG_ANGLE_SETPOINT  = 3'd0;
  localparam logic [2:0] REG_BALANCE_P_GAIN  = 3'd1;
  localparam logic [2:0] REG_BALANCE_D_GAIN  = 3'd2;
  localparam logic [2:0] REG_VELOCITY_P_GAIN = 3'd3;
  localparam logic [2:0] REG_VELOCITY_I_GAIN = 3'd4;
  localparam logic [2:0] REG_STEER_LIMIT     = 3'd5;
  localparam logic [2:0] REG_STEER_GAIN      = 3'd6;
  localparam logic [2:0] REG_DRIVE_LIMIT     = 3'd7;

  // sequencer steps
  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_BP   = 4'd1;
  localparam logic [3:0] ST_BD   = 4'd2;
  localparam logic [3:0] ST_BS   = 4'd3;
  localparam logic [3:0] ST_FM   = 4'd4;
  localparam logic [3:0] ST_FQ   = 4'd5;
  localparam logic [3:0] ST_FI   = 4'd6;
  localparam logic [3:0] ST_VI   = 4'd7;
  localparam logic [3:0] ST_VS   = 4'd8;
  localparam logic [3:0] ST_VT   = 4'd9;
  localparam logic [3:0] ST_SUM  = 4'd10;
  localparam logic [3:0] ST_DM   = 4'd11;
  localparam logic [3:0] ST_DQ   = 4'd12;

  typedef struct packed {
    logic signed [15:0] tilt_angle;
    logic signed [15:0] tilt_rate;
    logic signed [15:0] left_wheel_speed;
    logic signed [15:0] right_wheel_speed;
    logic signed [15:0] steer_request;
  } in_t;

  typedef struct packed {
    logic signed [13:0] motor_command;
    logic               motor_enable;
  } out_t;

  typedef struct packed {
    logic signed [12:0] angle_setpoint;
    logic [15:0]        balance_p_gain;
    logic [15:0]        balance_d_gain;
    logic [9:0]         velocity_p_gain;
    logic [15:0]        velocity_i_gain;
    logic [14:0]        steer_limit;
    logic [9:0]         steer_gain;
    logic [12:0]        drive_limit;
  } cfg_t;

  typedef struct packed {
    logic [3:0] step;
    logic       take_in;
    logic       load_out;
  } ctrl_t;

endpackage

`default_nettype wire

// ===== src/balance_robot_motor_controller.sv =====
// Two-wheel balance controller: usage notes
// Input channel (in_valid/in_ready/in_data) takes one sensor tick per
// transaction. Every second tick produces one result transaction on the
// output channel (out_valid/out_ready/out_data); the other ticks produce none.
// A tick that yields no result leaves the sequencer idle. A result tick runs 12
// sequencer steps through one shared signed multiplier and one accumulator;
// out_valid rises once the last step loads the output register, and the
// sequencer then returns to idle, ready for the next tick.
// The result sits in an output register; the sequencer only waits at its last
// step when the previous result has not been taken yet, so a stalled
// receiver holds off new result ticks but nothing is lost or repeated.
// Configuration: cfg_write/cfg_index/cfg_data write one register per cycle;
// the user must write only while the block is idle, which it does not enforce.
// Reset (rst, synchronous) clears the tick phase, the speed filter and the
// integral, drops any pending result and loads the register defaults.
// Depends on brmc_pkg, brmc_cfg, brmc_seq and brmc_dp.
`default_nettype none

module balance_robot_motor_controller (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire brmc_pkg::in_t  in_data,
  output logic                out_valid,
  input  wire logic           out_ready,
  output brmc_pkg::out_t      out_data,
  input  wire logic           cfg_write,
  input  wire logic [2:0]     cfg_index,
  input  wire logic [15:0]    cfg_data
);

  brmc_pkg::cfg_t  regs;
  brmc_pkg::ctrl_t ctrl;

  brmc_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .regs      (regs)
  );

  brmc_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .ctrl      (ctrl)
  );

  brmc_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (ctrl),
    .cfg      (regs),
    .in_data  (in_data),
    .out_data (out_data)
  );

  // a computation only starts right after an input transaction
  assert property (@(posedge clk) disable iff (rst)
    (ctrl.step == brmc_pkg::ST_BP) |-> $past(in_valid && in_ready))
    else $error("computation started without an input transaction");

  // loading the output register always raises out_valid
  assert property (@(posedge clk) disable iff (rst)
    ctrl.load_out |=> out_valid)
    else $error("result loaded but not presented");

  // presented command never exceeds the hard drive limit
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.motor_command <= 14'sd7200
                && out_data.motor_command >= -14'sd7200))
    else $error("motor command outside hard limit");

endmodule

`default_nettype wire

// ===== src/brmc_cfg.sv =====
// brmc_cfg: configuration register file with reset defaults.
// Depends on brmc_pkg.
`default_nettype none

module brmc_cfg (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          cfg_write,
  input  wire logic [2:0]    cfg_index,
  input  wire logic [15:0]   cfg_data,
  output brmc_pkg::cfg_t     regs
);

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.angle_setpoint  <= 13'sd0;
      regs.balance_p_gain  <= 16'd300;
      regs.balance_d_gain  <= 16'd256;
      regs.velocity_p_gain <= 10'd80;
      regs.velocity_i_gain <= 16'd102;
      regs.steer_limit     <= 15'd100;
      regs.steer_gain      <= 10'd42;
      regs.drive_limit     <= 13'd300;
    end else if (cfg_write) begin
      case (cfg_index)
        brmc_pkg::REG_ANGLE_SETPOINT:  regs.angle_setpoint  <= cfg_data[12:0];
        brmc_pkg::REG_BALANCE_P_GAIN:  regs.balance_p_gain  <= cfg_data;
        brmc_pkg::REG_BALANCE_D_GAIN:  regs.balance_d_gain  <= cfg_data;
        brmc_pkg::REG_VELOCITY_P_GAIN: regs.velocity_p_gain <= cfg_data[9:0];
        brmc_pkg::REG_VELOCITY_I_GAIN: regs.velocity_i_gain <= cfg_data;
        brmc_pkg::REG_STEER_LIMIT:     regs.steer_limit     <= cfg_data[14:0];
        brmc_pkg::REG_STEER_GAIN:      regs.steer_gain      <= cfg_data[9:0];
        brmc_pkg::REG_DRIVE_LIMIT:     regs.drive_limit     <= cfg_data[12:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== src/brmc_seq.sv =====
// brmc_seq: step sequencer, tick phase and output valid handling.
// Depends on brmc_pkg.
`default_nettype none

module brmc_seq (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  wire logic       out_ready,
  output brmc_pkg::ctrl_t ctrl
);

  logic [3:0] st;
  logic [3:0] st_next;
  logic       phase;

  assign in_ready = (st == brmc_pkg::ST_IDLE);

  always_comb begin
    ctrl.step     = st;
    ctrl.take_in  = in_valid && in_ready;
    ctrl.load_out = (st == brmc_pkg::ST_DQ) && (!out_valid || out_ready);
  end

  always_comb begin
    case (st)
      brmc_pkg::ST_IDLE: begin
        st_next = (ctrl.take_in && phase) ? brmc_pkg::ST_BP : brmc_pkg::ST_IDLE;
      end
      brmc_pkg::ST_BP, brmc_pkg::ST_BD, brmc_pkg::ST_BS, brmc_pkg::ST_FM,
      brmc_pkg::ST_FQ, brmc_pkg::ST_FI, brmc_pkg::ST_VI, brmc_pkg::ST_VS,
      brmc_pkg::ST_VT, brmc_pkg::ST_SUM, brmc_pkg::ST_DM: begin
        st_next = st + 4'd1;
      end
      brmc_pkg::ST_DQ: begin
        st_next = ctrl.load_out ? brmc_pkg::ST_IDLE : brmc_pkg::ST_DQ;
      end
      default: begin
        st_next = brmc_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= brmc_pkg::ST_IDLE;
      phase     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      st <= st_next;
      if (ctrl.take_in) begin
        phase <= ~phase;
      end
      if (ctrl.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// ===== src/brmc_dp.sv =====
// brmc_dp: datapath around one shared signed multiplier, with accumulator,
// filter and integral state and the output register. Depends on brmc_pkg.
`default_nettype none

module brmc_dp (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire brmc_pkg::ctrl_t ctrl,
  input  wire brmc_pkg::cfg_t  cfg,
  input  wire brmc_pkg::in_t   in_data,
  output brmc_pkg::out_t       out_data
);

  brmc_pkg::in_t       item;
  logic signed [27:0]  mul_a;
  logic signed [29:0]  mul_b;
  logic                mul_en;
  logic signed [57:0]  prod;
  logic signed [47:0]  acc;
  logic signed [27:0]  num;
  logic                neg;
  logic signed [25:0]  bal;
  logic signed [27:0]  vel;
  logic signed [25:0]  fs;
  logic signed [22:0]  integ;

  logic signed [16:0]  angle17;
  logic signed [16:0]  setpt17;
  logic signed [16:0]  bias;
  logic signed [16:0]  steer17;
  logic signed [16:0]  slim;
  logic signed [16:0]  slim_neg;
  logic signed [16:0]  steer_cl;
  logic signed [27:0]  num_abs;
  logic [26:0]         mag;
  logic signed [16:0]  lr;
  logic signed [27:0]  fs_num;
  logic signed [47:0]  bal_r;
  logic signed [47:0]  bal_sh;
  logic signed [47:0]  vel_r;
  logic signed [47:0]  vel_sh;
  logic signed [57:0]  filt_sh;
  logic signed [25:0]  fs_new;
  logic signed [26:0]  isum;
  logic signed [26:0]  integ_new;
  logic signed [27:0]  bal28;
  logic signed [27:0]  turn28;
  logic signed [27:0]  sum_new;
  logic signed [57:0]  drive_sh;
  logic signed [27:0]  cmd;
  logic [12:0]         eff_lim;
  logic signed [27:0]  lim_pos;
  logic signed [27:0]  lim_neg;
  logic signed [27:0]  cmd_cl;
  logic                enable;

  always_comb begin
    angle17  = {item.tilt_angle[15], item.tilt_angle};
    setpt17  = {{4{cfg.angle_setpoint[12]}}, cfg.angle_setpoint};
    bias     = angle17 - setpt17;
    steer17  = {item.steer_request[15], item.steer_request};
    slim     = {2'b00, cfg.steer_limit};
    slim_neg = -slim;
    if (steer17 > slim) begin
      steer_cl = slim;
    end else if (steer17 < slim_neg) begin
      steer_cl = slim_neg;
    end else begin
      steer_cl = steer17;
    end
    num_abs = num[27] ? -num : num;
    mag     = num_abs[26:0];
    lr      = {item.left_wheel_speed[15], item.left_wheel_speed}
            + {item.right_wheel_speed[15], item.right_wheel_speed};
    fs_num  = {fs, 2'b00} + {{3{lr[16]}}, lr, 8'h00};
  end

  // operand select for the shared multiplier
  always_comb begin
    mul_en = 1'b1;
    case (ctrl.step)
      brmc_pkg::ST_BP: begin
        mul_a = {{11{bias[16]}}, bias};
        mul_b = {14'd0, cfg.balance_p_gain};
      end
      brmc_pkg::ST_BD: begin
        mul_a = {{12{item.tilt_rate[15]}}, item.tilt_rate};
        mul_b = {14'd0, cfg.balance_d_gain};
      end
      brmc_pkg::ST_FM: begin
        mul_a = {1'b0, mag};
        mul_b = {1'b0, brmc_pkg::FILT_RECIP};
      end
      brmc_pkg::ST_FI: begin
        mul_a = {{2{fs[25]}}, fs};
        mul_b = {20'd0, cfg.velocity_p_gain};
      end
      brmc_pkg::ST_VI: begin
        mul_a = {{5{integ[22]}}, integ};
        mul_b = {14'd0, cfg.velocity_i_gain};
      end
      brmc_pkg::ST_VS: begin
        mul_a = {{11{steer_cl[16]}}, steer_cl};
        mul_b = {20'd0, cfg.steer_gain};
      end
      brmc_pkg::ST_DM: begin
        mul_a = {1'b0, mag};
        mul_b = {1'b0, brmc_pkg::DRIVE_RECIP};
      end
      default: begin
        mul_a  = '0;
        mul_b  = '0;
        mul_en = 1'b0;
      end
    endcase
  end

  always_comb begin
    bal_r   = acc + (acc[47] ? 48'sd4095 : 48'sd0);
    bal_sh  = bal_r >>> 12;
    vel_r   = acc + (acc[47] ? 48'sd65535 : 48'sd0);
    vel_sh  = vel_r >>> 16;

    filt_sh = prod >>> brmc_pkg::FILT_SHIFT;
    fs_new  = neg ? -{1'b0, filt_sh[24:0]} : {1'b0, filt_sh[24:0]};

    isum = {{4{integ[22]}}, integ} + {fs[25], fs};
    if (isum > brmc_pkg::INTEG_LIMIT) begin
      integ_new = brmc_pkg::INTEG_LIMIT;
    end else if (isum < -brmc_pkg::INTEG_LIMIT) begin
      integ_new = -brmc_pkg::INTEG_LIMIT;
    end else begin
      integ_new = isum;
    end

    bal28   = {{2{bal[25]}}, bal};
    turn28  = {{2{prod[25]}}, prod[25:0]};
    sum_new = bal28 - vel + turn28;

    drive_sh = prod >>> brmc_pkg::DRIVE_SHIFT;
    cmd      = neg ? -{1'b0, drive_sh[26:0]} : {1'b0, drive_sh[26:0]};
    eff_lim  = (cfg.drive_limit > brmc_pkg::COMMAND_MAX) ? brmc_pkg::COMMAND_MAX
                                                         : cfg.drive_limit;
    lim_pos  = {15'd0, eff_lim};
    lim_neg  = -lim_pos;
    if (cmd > lim_pos) begin
      cmd_cl = lim_pos;
    end else if (cmd < lim_neg) begin
      cmd_cl = lim_neg;
    end else begin
      cmd_cl = cmd;
    end

    enable = (item.tilt_angle >= -brmc_pkg::TILT_LIMIT)
          && (item.tilt_angle <= brmc_pkg::TILT_LIMIT);
  end

  // controller state
  always_ff @(posedge clk) begin
    if (rst) begin
      fs    <= '0;
      integ <= '0;
    end else begin
      if (ctrl.step == brmc_pkg::ST_FQ) begin
        fs <= fs_new;
      end
      if (ctrl.step == brmc_pkg::ST_FI) begin
        integ <= integ_new[22:0];
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (ctrl.take_in) begin
      item <= in_data;
    end
    if (mul_en) begin
      prod <= mul_a * mul_b;
    end
    case (ctrl.step)
      brmc_pkg::ST_BD: begin
        acc <= {prod[43:0], 4'h0};
      end
      brmc_pkg::ST_BS: begin
        acc <= acc + prod[47:0];
        num <= fs_num;
      end
      brmc_pkg::ST_FM: begin
        bal <= bal_sh[25:0];
        neg <= num[27];
      end
      brmc_pkg::ST_VI: begin
        acc <= {prod[39:0], 8'h00};
      end
      brmc_pkg::ST_VS: begin
        acc <= acc + prod[47:0];
      end
      brmc_pkg::ST_VT: begin
        vel <= vel_sh[27:0];
      end
      brmc_pkg::ST_SUM: begin
        num <= sum_new;
      end
      brmc_pkg::ST_DM: begin
        neg <= num[27];
      end
      brmc_pkg::ST_DQ: begin
        if (ctrl.load_out) begin
          out_data.motor_command <= cmd_cl[13:0];
          out_data.motor_enable  <= enable;
        end
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire
